@@ hw/rtl/mafs_pkg.sv @@
// ----------------------------------------------------------------------------
// MPEG audio frame splitter - shared definitions
// Widths, header field codes, bitrate table and the command/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package mafs_pkg;

   localparam int LENGTH_WIDTH      = 11;
   localparam int BYTE_WIDTH        = 8;
   localparam int FRAME_BYTES_WIDTH = 11;
   localparam int HOLD_WIDTH        = 24;
   localparam int KBPS_WIDTH        = 9;
   localparam int SCALE_WIDTH       = 18;
   localparam int DIVIDEND_WIDTH    = 26;
   localparam int DIVISOR_WIDTH     = 16;
   localparam int QUO_WIDTH         = 12;
   localparam int DIV_CNT_WIDTH     = $clog2(QUO_WIDTH + 1);
   localparam int LEN_CALC_WIDTH    = 17;

   localparam logic [LEN_CALC_WIDTH-1:0] LEN_MAX  = LEN_CALC_WIDTH'((1 << LENGTH_WIDTH) - 1);
   localparam logic [LEN_CALC_WIDTH-1:0] LEN_MIN  = LEN_CALC_WIDTH'(4);
   localparam logic [LENGTH_WIDTH-1:0]   HDR_LEN  = LENGTH_WIDTH'(4);

   localparam logic [10:0] SYNC_WORD = 11'h7ff;

   localparam logic [1:0] VER_MPEG25   = 2'd0;
   localparam logic [1:0] VER_RESERVED = 2'd1;
   localparam logic [1:0] VER_MPEG2    = 2'd2;
   localparam logic [1:0] VER_MPEG1    = 2'd3;

   localparam logic [1:0] LAY_RESERVED = 2'd0;
   localparam logic [1:0] LAY_CODE_I   = 2'd3;

   localparam logic [1:0] LIDX_I   = 2'd0;
   localparam logic [1:0] LIDX_III = 2'd2;

   localparam logic [1:0] SRATE_RESERVED = 2'd3;
   localparam logic [1:0] SRATE_44K1     = 2'd0;
   localparam logic [1:0] SRATE_48K      = 2'd1;
   localparam logic [1:0] SRATE_32K      = 2'd2;

   localparam logic [3:0] BIDX_FREE = 4'd0;
   localparam logic [3:0] BIDX_BAD  = 4'd15;

   typedef logic [KBPS_WIDTH-1:0] kbps_type;

   localparam kbps_type KBPS_TAB [2][3][15] = '{
      '{ '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
           9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448},
         '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384},
         '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
           9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320} },
      '{ '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256},
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160},
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160} }
   };

   function automatic kbps_type kbps_of(input logic lsf, input logic [1:0] lidx,
                                        input logic [3:0] bidx);
      kbps_type k;
      k = '0;
      if (bidx != BIDX_BAD && lidx <= LIDX_III) begin
         k = KBPS_TAB[lsf][lidx][bidx];
      end
      return k;
   endfunction

   // slots per kbit/s, scaled by 1000 (a slot is one byte, four in layer I)
   function automatic logic [SCALE_WIDTH-1:0] scale_of(input logic lsf,
                                                       input logic [1:0] lidx);
      logic [SCALE_WIDTH-1:0] s;
      if (lidx == LIDX_I) begin
         s = SCALE_WIDTH'(12 * 1000);
      end else if (lidx == LIDX_III && lsf) begin
         s = SCALE_WIDTH'(72 * 1000);
      end else begin
         s = SCALE_WIDTH'(144 * 1000);
      end
      return s;
   endfunction

   function automatic logic [DIVISOR_WIDTH-1:0] rate_of(input logic [1:0] ver,
                                                        input logic [1:0] sidx);
      logic [DIVISOR_WIDTH-1:0] base;
      logic [DIVISOR_WIDTH-1:0] r;
      case (sidx)
         SRATE_44K1: base = DIVISOR_WIDTH'(44100);
         SRATE_48K:  base = DIVISOR_WIDTH'(48000);
         SRATE_32K:  base = DIVISOR_WIDTH'(32000);
         default:    base = '0;
      endcase
      case (ver)
         VER_MPEG1:  r = base;
         VER_MPEG2:  r = base >> 1;
         default:    r = base >> 2;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic hdr_shift;
      logic hdr_last;
      logic div_start;
      logic len_load;
      logic frame_init;
      logic out_head;
      logic out_pass;
      logic out_err;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hdr_full;
      logic hdr_ok;
      logic div_done;
      logic len_ok;
      logic head_last;
      logic left_zero;
      logic left_one;
      logic out_free;
   } dp_status_type;

endpackage

@@ hw/rtl/mafs_if.sv @@
// ----------------------------------------------------------------------------
// MPEG audio frame splitter - stream channels
// Valid/ready channels for incoming stream bytes and outgoing frame bytes.
// ----------------------------------------------------------------------------
interface mafs_req_if;
   import mafs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface mafs_rsp_if;
   import mafs_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [BYTE_WIDTH-1:0]        frame_byte;
   logic                         frame_start;
   logic                         frame_end;
   logic [FRAME_BYTES_WIDTH-1:0] frame_bytes;
   logic                         header_error;

   modport source (output valid, output frame_byte, output frame_start, output frame_end,
                   output frame_bytes, output header_error, input ready);
   modport sink   (input valid, input frame_byte, input frame_start, input frame_end,
                   input frame_bytes, input header_error, output ready);
endinterface

@@ hw/rtl/mafs_div.sv @@
// ----------------------------------------------------------------------------
// MPEG audio frame splitter - length divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mafs_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [mafs_pkg::DIVIDEND_WIDTH-1:0] dividend,
   input  logic [mafs_pkg::DIVISOR_WIDTH-1:0]  divisor,
   output logic                                done,
   output logic [mafs_pkg::QUO_WIDTH-1:0]      quotient
);
   import mafs_pkg::*;

   logic [DIVISOR_WIDTH-1:0] rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0] dsr_ff;
   logic [QUO_WIDTH-1:0]     low_ff, low_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic [DIVISOR_WIDTH:0]   trial;
   logic [DIVISOR_WIDTH:0]   diff;
   logic                     ge;

   assign trial  = {rem_ff, low_ff[QUO_WIDTH-1]};
   assign diff   = trial - {1'b0, dsr_ff};
   assign ge     = trial >= {1'b0, dsr_ff};
   assign rem_in = ge ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
   assign low_in = {low_ff[QUO_WIDTH-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_WIDTH'(QUO_WIDTH);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_WIDTH'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DIVISOR_WIDTH'(dividend[DIVIDEND_WIDTH-1:QUO_WIDTH]);
         low_ff <= dividend[QUO_WIDTH-1:0];
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
      end
   end

   assign done     = done_ff;
   assign quotient = low_ff;

endmodule

@@ hw/rtl/mafs_datapath.sv @@
// ----------------------------------------------------------------------------
// MPEG audio frame splitter - datapath
// Header capture, length arithmetic, byte countdown and result register.
// ----------------------------------------------------------------------------
module mafs_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mafs_pkg::ctrl_cmd_type                 cmd,
   output mafs_pkg::dp_status_type                status,
   input  logic [mafs_pkg::BYTE_WIDTH-1:0]        stream_byte,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic [mafs_pkg::BYTE_WIDTH-1:0]        frame_byte,
   output logic                                   frame_start,
   output logic                                   frame_end,
   output logic [mafs_pkg::FRAME_BYTES_WIDTH-1:0] frame_bytes,
   output logic                                   header_error
);
   import mafs_pkg::*;

   logic [HOLD_WIDTH-1:0]     hold_ff;
   logic [BYTE_WIDTH-1:0]     byte4_ff;
   logic [1:0]                count_ff;
   logic [1:0]                head_idx_ff;
   logic [LENGTH_WIDTH-1:0]   len_ff;
   logic                      len_ok_ff;
   logic [LENGTH_WIDTH-1:0]   left_ff;
   logic                      valid_ff;
   logic [BYTE_WIDTH-1:0]     obyte_ff;
   logic                      ostart_ff;
   logic                      oend_ff;
   logic [FRAME_BYTES_WIDTH-1:0] obytes_ff;
   logic                      oerr_ff;

   logic [10:0]               sync;
   logic [1:0]                ver;
   logic [1:0]                lay;
   logic [3:0]                bidx;
   logic [1:0]                sidx;
   logic                      pad;
   logic                      lsf;
   logic [1:0]                lidx;
   logic [DIVIDEND_WIDTH-1:0] product;
   logic                      div_done;
   logic [QUO_WIDTH-1:0]      quotient;
   logic [QUO_WIDTH:0]        slots;
   logic [LEN_CALC_WIDTH-1:0] len_full;
   logic [BYTE_WIDTH-1:0]     head_byte;
   logic                      out_free;

   assign sync = hold_ff[23:13];
   assign ver  = hold_ff[12:11];
   assign lay  = hold_ff[10:9];
   assign bidx = hold_ff[7:4];
   assign sidx = hold_ff[3:2];
   assign pad  = hold_ff[1];
   assign lsf  = ver != VER_MPEG1;
   assign lidx = LAY_CODE_I - lay;

   assign product = DIVIDEND_WIDTH'(kbps_of(lsf, lidx, bidx)) *
                    DIVIDEND_WIDTH'(scale_of(lsf, lidx));

   mafs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (product),
      .divisor  (rate_of(ver, sidx)),
      .done     (div_done),
      .quotient (quotient)
   );

   assign slots    = {1'b0, quotient} + (QUO_WIDTH + 1)'(pad);
   assign len_full = (lidx == LIDX_I) ? LEN_CALC_WIDTH'({slots, 2'b00})
                                      : LEN_CALC_WIDTH'(slots);

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      case (head_idx_ff)
         2'd0:    head_byte = hold_ff[23:16];
         2'd1:    head_byte = hold_ff[15:8];
         2'd2:    head_byte = hold_ff[7:0];
         default: head_byte = byte4_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.hdr_shift) begin
            count_ff <= count_ff + 1'b1;
         end else if (cmd.hdr_last) begin
            count_ff <= '0;
         end
         if (cmd.out_head || cmd.out_pass || cmd.out_err) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hdr_shift) begin
         hold_ff <= {hold_ff[HOLD_WIDTH-BYTE_WIDTH-1:0], stream_byte};
      end
      if (cmd.hdr_last) begin
         byte4_ff <= stream_byte;
      end
      if (cmd.len_load) begin
         len_ff    <= len_full[LENGTH_WIDTH-1:0];
         len_ok_ff <= (len_full >= LEN_MIN) && (len_full <= LEN_MAX);
      end
      if (cmd.frame_init) begin
         left_ff     <= len_ff - HDR_LEN;
         head_idx_ff <= '0;
      end else if (cmd.out_pass) begin
         left_ff <= left_ff - 1'b1;
      end else if (cmd.out_head) begin
         head_idx_ff <= head_idx_ff + 1'b1;
      end
      if (cmd.out_err) begin
         obyte_ff  <= '0;
         ostart_ff <= 1'b0;
         oend_ff   <= 1'b0;
         obytes_ff <= '0;
         oerr_ff   <= 1'b1;
      end else if (cmd.out_head) begin
         obyte_ff  <= head_byte;
         ostart_ff <= head_idx_ff == 2'd0;
         oend_ff   <= (head_idx_ff == 2'd3) && (left_ff == '0);
         obytes_ff <= len_ff[FRAME_BYTES_WIDTH-1:0];
         oerr_ff   <= 1'b0;
      end else if (cmd.out_pass) begin
         obyte_ff  <= stream_byte;
         ostart_ff <= 1'b0;
         oend_ff   <= left_ff == LENGTH_WIDTH'(1);
         obytes_ff <= len_ff[FRAME_BYTES_WIDTH-1:0];
         oerr_ff   <= 1'b0;
      end
   end

   always_comb begin
      status.hdr_full  = count_ff == 2'd3;
      status.hdr_ok    = (sync == SYNC_WORD) && (ver != VER_RESERVED) &&
                         (lay != LAY_RESERVED) && (sidx != SRATE_RESERVED) &&
                         (bidx != BIDX_FREE) && (bidx != BIDX_BAD);
      status.div_done  = div_done;
      status.len_ok    = len_ok_ff;
      status.head_last = head_idx_ff == 2'd3;
      status.left_zero = left_ff == '0;
      status.left_one  = left_ff == LENGTH_WIDTH'(1);
      status.out_free  = out_free;
   end

   assign rsp_valid    = valid_ff;
   assign frame_byte   = obyte_ff;
   assign frame_start  = ostart_ff;
   assign frame_end    = oend_ff;
   assign frame_bytes  = obytes_ff;
   assign header_error = oerr_ff;

endmodule

@@ hw/rtl/mafs_ctrl.sv @@
// ----------------------------------------------------------------------------
// MPEG audio frame splitter - controller
// Sequences header capture, length division, header replay and pass-through.
// ----------------------------------------------------------------------------
module mafs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mafs_pkg::dp_status_type status,
   output mafs_pkg::ctrl_cmd_type  cmd
);
   import mafs_pkg::*;

   localparam logic [2:0] S_GATHER = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_HEAD   = 3'd4;
   localparam logic [2:0] S_PASS   = 3'd5;
   localparam logic [2:0] S_ERR    = 3'd6;
   localparam logic [2:0] S_STALL  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      case (state_ff)
         S_GATHER: req_ready = 1'b1;
         S_PASS:   req_ready = status.out_free;
         S_STALL:  req_ready = 1'b1;
         default:  req_ready = 1'b0;
      endcase
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_GATHER: begin
            if (accept) begin
               if (status.hdr_full) begin
                  cmd.hdr_last = 1'b1;
                  state_in     = status.hdr_ok ? S_START : S_ERR;
               end else begin
                  cmd.hdr_shift = 1'b1;
               end
            end
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.len_load = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.len_ok) begin
               cmd.frame_init = 1'b1;
               state_in       = S_HEAD;
            end else begin
               state_in = S_ERR;
            end
         end
         S_HEAD: begin
            if (status.out_free) begin
               cmd.out_head = 1'b1;
               if (status.head_last) begin
                  state_in = status.left_zero ? S_GATHER : S_PASS;
               end
            end
         end
         S_PASS: begin
            if (accept) begin
               cmd.out_pass = 1'b1;
               if (status.left_one) begin
                  state_in = S_GATHER;
               end
            end
         end
         S_ERR: begin
            if (status.out_free) begin
               cmd.out_err = 1'b1;
               state_in    = S_STALL;
            end
         end
         S_STALL: state_in = S_STALL;
         default: state_in = S_GATHER;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_GATHER;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/mpeg_audio_frame_splitter.sv @@
// ----------------------------------------------------------------------------
// MPEG audio frame splitter - top level
// Cuts an MPEG audio byte stream into frames, marking start and end of each.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  req_if   in         stream_byte, one byte per request
//  rsp_if   out        frame_byte, frame_start, frame_end, frame_bytes,
//                      header_error
//
//  Header bytes: the fourth starts the length divide on a good header, then
//  the length is checked and the four header bytes are replayed.
//  Body bytes pass through at one per cycle while rsp_if keeps up.
//  Reset is synchronous and returns the block to header capture.
//  A bad header gives one error result, after which input is drained
//  without results until reset. A stalled rsp_if holds the result register.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_splitter (
   input logic        clock,
   input logic        reset,
   mafs_req_if.sink   req_if,
   mafs_rsp_if.source rsp_if
);
   import mafs_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mafs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mafs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .stream_byte  (req_if.stream_byte),
      .rsp_ready    (rsp_if.ready),
      .rsp_valid    (rsp_if.valid),
      .frame_byte   (rsp_if.frame_byte),
      .frame_start  (rsp_if.frame_start),
      .frame_end    (rsp_if.frame_end),
      .frame_bytes  (rsp_if.frame_bytes),
      .header_error (rsp_if.header_error)
   );

   a_err_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.header_error) |=> !rsp_if.valid)
      else $error("result issued after header error");

   a_start_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.frame_start) |->
      (!rsp_if.header_error && rsp_if.frame_bytes >= FRAME_BYTES_WIDTH'(4)))
      else $error("frame start with bad length");

   a_div_idle_input: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> !req_if.ready)
      else $error("input taken while length divide in flight");

   a_out_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_head || cmd.out_pass || cmd.out_err) |-> status.out_free)
      else $error("result register overwritten");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPEG audio frame splitter - testbench
// Feeds a stream of well-formed frames with random header fields and random
// bodies, with bursty requests and a stalling receiver. Each accepted byte
// runs through an untimed model of the splitter. Every frame byte that
// comes out is checked against it. The stream ends with one bad header,
// which leaves the block stalled, and a few trailing bytes that it must drop.
// ----------------------------------------------------------------------------
module tb;
   import mafs_pkg::*;

   localparam int          CYCLE_LIMIT    = 600000;
   localparam int          RANDOM_ITEMS   = 430;
   localparam int unsigned SHORT_FRAME    = 160;
   localparam int          HOLD_AFTER     = 60;
   localparam int          HOLD_CYCLES    = 400;
   localparam int          DRAIN_CYCLES   = 40;
   localparam int          REPORT_LIMIT   = 100;
   localparam logic [1:0]  LAY_CODE_III   = 2'd1;
   localparam logic [3:0]  BIDX_LOWEST    = 4'd1;

   typedef enum int {
      BAD_SYNC, BAD_VERSION, BAD_LAYER, BAD_RATE, BAD_FREE_FORMAT, BAD_INDEX,
      BAD_TOO_LONG
   } bad_header_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]        frame_byte;
      logic                         frame_start;
      logic                         frame_end;
      logic [FRAME_BYTES_WIDTH-1:0] frame_bytes;
      logic                         header_error;
   } frame_rsp_type;

   logic clock;
   logic reset;

   mafs_req_if req_ch ();
   mafs_rsp_if rsp_ch ();

   mpeg_audio_frame_splitter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   int unsigned rate_hz [3] = '{44100, 48000, 32000};
   int unsigned kbps_table [2][3][15] = '{
      '{ '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
         '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
         '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320} },
      '{ '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
         '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160},
         '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160} }
   };

   // splitter model state
   logic [HOLD_WIDTH-1:0]   held_header;
   logic [1:0]              hdr_count;
   logic [LENGTH_WIDTH-1:0] body_left;
   logic                    split_stalled;
   frame_rsp_type           frame_due_q [$];

   logic [BYTE_WIDTH-1:0]   stream_q [$];
   logic [BYTE_WIDTH-1:0]   cur_byte;
   logic                    have_item;
   logic                    req_taken;
   int                      burst_left;
   int                      gap_left;
   int                      stream_total;
   int                      taken_count;
   int                      result_count;
   int                      error_count;
   int                      cycle_count;

   logic [15:0]             stall_pattern;
   int                      stall_phase;
   int                      hold_left;
   logic                    hold_done;
   frame_rsp_type           want;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // frame length in bytes from the first three header bytes, 0 on bad fields
   function automatic int unsigned frame_length_of(input logic [HOLD_WIDTH-1:0] h);
      logic [10:0] sync;
      logic [1:0]  ver;
      logic [1:0]  lay;
      logic [1:0]  sidx;
      logic [3:0]  bidx;
      int unsigned pad;
      int unsigned lsf;
      int unsigned layer;
      int unsigned shift;
      int unsigned rate;
      int unsigned br;
      int unsigned len;
      sync = h[23:13];
      ver  = h[12:11];
      lay  = h[10:9];
      bidx = h[7:4];
      sidx = h[3:2];
      pad  = h[1];
      len  = 0;
      if (sync == SYNC_WORD && ver != VER_RESERVED && lay != LAY_RESERVED &&
          sidx != SRATE_RESERVED && bidx != BIDX_FREE && bidx != BIDX_BAD) begin
         lsf   = (ver == VER_MPEG1) ? 0 : 1;
         shift = (ver == VER_MPEG1) ? 0 : ((ver == VER_MPEG2) ? 1 : 2);
         layer = LAY_CODE_I - lay;
         rate  = rate_hz[sidx] >> shift;
         br    = kbps_table[lsf][layer][bidx] * 1000;
         if (layer == LIDX_I) begin
            len = (12 * br / rate + pad) * 4;
         end else if (layer == LIDX_III && lsf == 1) begin
            len = 72 * br / rate + pad;
         end else begin
            len = 144 * br / rate + pad;
         end
      end
      return len;
   endfunction

   task automatic push_due(input logic [BYTE_WIDTH-1:0] b, input logic first,
                           input logic last, input int unsigned len, input logic err);
      frame_rsp_type r;
      r.frame_byte   = b;
      r.frame_start  = first;
      r.frame_end    = last;
      r.frame_bytes  = FRAME_BYTES_WIDTH'(len);
      r.header_error = err;
      frame_due_q.push_back(r);
   endtask

   task automatic split_stream_byte(input logic [BYTE_WIDTH-1:0] b);
      int unsigned len;
      if (split_stalled) begin
         // drop everything until reset
      end else if (body_left != 0) begin
         len = frame_length_of(held_header);
         push_due(b, 1'b0, body_left == 1, len, 1'b0);
         body_left = body_left - 1'b1;
      end else if (hdr_count < 3) begin
         held_header = {held_header[15:0], b};
         hdr_count   = hdr_count + 1'b1;
      end else begin
         hdr_count = '0;
         len = frame_length_of(held_header);
         if (len < 4 || len > LEN_MAX) begin
            split_stalled = 1'b1;
            push_due('0, 1'b0, 1'b0, 0, 1'b1);
         end else begin
            push_due(held_header[23:16], 1'b1, 1'b0, len, 1'b0);
            push_due(held_header[15:8], 1'b0, 1'b0, len, 1'b0);
            push_due(held_header[7:0], 1'b0, 1'b0, len, 1'b0);
            push_due(b, 1'b0, len == 4, len, 1'b0);
            body_left = LENGTH_WIDTH'(len - 4);
         end
      end
   endtask

   function automatic logic [31:0] rand_header_word();
      logic [1:0] ver;
      case ($urandom_range(0, 2))
         0:       ver = VER_MPEG25;
         1:       ver = VER_MPEG2;
         default: ver = VER_MPEG1;
      endcase
      return {8'hff, 3'b111, ver, 2'($urandom_range(LAY_RESERVED + 1, LAY_CODE_I)),
              1'($urandom), 4'($urandom_range(BIDX_FREE + 1, BIDX_BAD - 1)),
              2'($urandom_range(0, SRATE_RESERVED - 1)), 2'($urandom),
              8'($urandom)};
   endfunction

   task automatic pick_header(input int unsigned cap, output logic [31:0] w);
      int unsigned len;
      do begin
         w   = rand_header_word();
         len = frame_length_of(w[31:8]);
      end while (len < 4 || len > LEN_MAX || len > cap);
   endtask

   task automatic push_header(input logic [31:0] w);
      stream_q.push_back(w[31:24]);
      stream_q.push_back(w[23:16]);
      stream_q.push_back(w[15:8]);
      stream_q.push_back(w[7:0]);
   endtask

   task automatic queue_frame(input logic [31:0] w);
      int unsigned len;
      len = frame_length_of(w[31:8]);
      push_header(w);
      for (int unsigned i = 4; i < len; i++) begin
         stream_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic build_stream();
      logic [31:0]    w;
      int             random_items;
      bad_header_type kind;
      // shortest frame there is, body of all-zero and all-one bytes
      w = {8'hff, 3'b111, VER_MPEG2, LAY_CODE_III, 1'b1, BIDX_LOWEST, SRATE_48K,
           2'b00, 8'h00};
      push_header(w);
      for (int i = 4; i < frame_length_of(w[31:8]); i++) begin
         stream_q.push_back((i % 2 == 0) ? 8'h00 : 8'hff);
      end
      random_items = stream_q.size();
      while (random_items < RANDOM_ITEMS) begin
         pick_header(SHORT_FRAME, w);
         queue_frame(w);
         random_items = stream_q.size();
      end
      // one bad header closes the run, then bytes that must be dropped
      kind = bad_header_type'($urandom_range(BAD_SYNC, BAD_TOO_LONG));
      pick_header(LEN_MAX, w);
      case (kind)
         BAD_SYNC:        w[31:21] = w[31:21] ^ 11'($urandom_range(1, 2047));
         BAD_VERSION:     w[20:19] = VER_RESERVED;
         BAD_LAYER:       w[18:17] = LAY_RESERVED;
         BAD_RATE:        w[11:10] = SRATE_RESERVED;
         BAD_FREE_FORMAT: w[15:12] = BIDX_FREE;
         BAD_INDEX:       w[15:12] = BIDX_BAD;
         default: begin
            do begin
               w = rand_header_word();
            end while (frame_length_of(w[31:8]) <= LEN_MAX);
         end
      endcase
      push_header(w);
      for (int i = 0; i < 6; i++) begin
         stream_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic compare_field(input string name, input int unsigned exp_val,
                                input int unsigned got_val);
      if (exp_val != got_val) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
         end
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_taken) begin
            req_taken = 1'b0;
            have_item = 1'b0;
         end
         if (!have_item) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (stream_q.size() != 0) begin
               cur_byte  = stream_q.pop_front();
               have_item = 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end
         req_ch.valid       <= have_item;
         req_ch.stream_byte <= cur_byte;
      end
   end

   // result receiver: stall pattern, plus one long hold to back up the block
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && result_count >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (stall_phase == 0) begin
            stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
         end
         rsp_ch.ready <= stall_pattern[stall_phase];
         stall_phase = (stall_phase + 1) % 16;
      end
   end

   // monitor: predict on each accepted request, then check each result
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            split_stream_byte(req_ch.stream_byte);
            req_taken = 1'b1;
            taken_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            result_count++;
            if (frame_due_q.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $error("unexpected result: frame_byte 0x%0h header_error %0b",
                         rsp_ch.frame_byte, rsp_ch.header_error);
               end
            end else begin
               want = frame_due_q.pop_front();
               compare_field("frame_byte", want.frame_byte, rsp_ch.frame_byte);
               compare_field("frame_start", want.frame_start, rsp_ch.frame_start);
               compare_field("frame_end", want.frame_end, rsp_ch.frame_end);
               compare_field("frame_bytes", want.frame_bytes, rsp_ch.frame_bytes);
               compare_field("header_error", want.header_error, rsp_ch.header_error);
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.stream_byte = '0;
      rsp_ch.ready       = 1'b0;
      held_header        = '0;
      hdr_count          = '0;
      body_left          = '0;
      split_stalled      = 1'b0;
      cur_byte           = '0;
      have_item          = 1'b0;
      req_taken          = 1'b0;
      burst_left         = 0;
      gap_left           = 0;
      taken_count        = 0;
      result_count       = 0;
      error_count        = 0;
      stall_pattern      = 16'hffff;
      stall_phase        = 0;
      hold_left          = 0;
      hold_done          = 1'b0;
      build_stream();
      stream_total = stream_q.size();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (taken_count == stream_total);
      while (frame_due_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frame_due_q.size() != 0) begin
         error_count += frame_due_q.size();
         $error("%0d expected results never arrived", frame_due_q.size());
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/mafs_pkg.sv
hw/rtl/mafs_if.sv
hw/rtl/mafs_div.sv
hw/rtl/mafs_datapath.sv
hw/rtl/mafs_ctrl.sv
hw/rtl/mpeg_audio_frame_splitter.sv
tb/tb.sv
